// ----- rtl/tce_pkg.sv -----
package tce_pkg;

  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned REG_COUNT  = 16;
  localparam int unsigned MEM_AW     = $clog2(DATA_WORDS);

  localparam logic [15:0] BASE_RESET = 16'd16384;
  localparam logic [15:0] PC_STEP    = 16'd4;

  typedef enum logic [7:0] {
    OP_STOP = 8'd0,
    OP_MOVE = 8'd1,
    OP_ADD  = 8'd2,
    OP_SUB  = 8'd3,
    OP_MUL  = 8'd4,
    OP_DIV  = 8'd5,
    OP_AND  = 8'd6,
    OP_OR   = 8'd7,
    OP_NOT  = 8'd8,
    OP_CMP  = 8'd9,
    OP_JUMP = 8'd10,
    OP_IN   = 8'd11,
    OP_OUT  = 8'd12
  } opcode_e;

  localparam logic [3:0] JMP_ALWAYS = 4'd0;
  localparam logic [3:0] JMP_EQ     = 4'd1;
  localparam logic [3:0] JMP_GT     = 4'd2;
  localparam logic [3:0] JMP_LT     = 4'd3;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

endpackage

// ----- rtl/tce_if.sv -----
interface tce_req_if;
  logic               valid;
  logic               ready;
  logic [7:0]         opcode;
  logic [3:0]         reg_a;
  logic [3:0]         reg_b;
  logic signed [15:0] immediate;
  logic signed [31:0] in_value;

  modport source (output valid, opcode, reg_a, reg_b, immediate, in_value, input ready);
  modport sink (input valid, opcode, reg_a, reg_b, immediate, in_value, output ready);
endinterface

interface tce_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic signed [1:0]  flag;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               reg_written;
  logic [3:0]         written_index;
  logic signed [31:0] written_value;
  logic               divide_error;

  modport source (output valid, next_pc, flag, out_valid, out_value, reg_written,
                  written_index, written_value, divide_error, input ready);
  modport sink (input valid, next_pc, flag, out_valid, out_value, reg_written,
                written_index, written_value, divide_error, output ready);
endinterface

// ----- rtl/toy_cpu_execute_unit_top.sv -----
// toy cpu execute unit
// req_i carries one decoded instruction per request (opcode, reg_a, reg_b,
// immediate, in_value); res_o returns exactly one result per request with
// the new program counter, compare flag, output value, register write and
// divide error indication. both channels use valid/ready.
// data_base is written through the apb port at byte address 0 (paddr[2]
// low); pready is always high and a read there returns the current base.
// after reset the data memory is swept to zero, one word per cycle, and
// req_i.ready stays low meanwhile.
// an instruction goes through register file read, data memory read,
// execute and write back before the next request is taken; divide adds
// the radix-2 iterative divider state. state lives in a 16-entry register
// file and a 1024-word data memory, both with registered reads.
// the result is held in an output register; if the receiver stalls, the
// unit finishes the next instruction up to write back and waits there.
module toy_cpu_execute_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tce_req_if.sink     req_i,
  tce_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = tce_pkg::MEM_AW;
  localparam int unsigned RC = tce_pkg::REG_COUNT;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RREG = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [15:0] base_q;
  logic [15:0] pc_q;
  logic [1:0]  flag_q;
  logic [AW-1:0] clr_cnt_q;

  // latched request
  logic [7:0]  op_q;
  logic [3:0]  ra_q, rb_q;
  logic [15:0] imm_q;
  logic [31:0] inval_q;

  // storage
  logic [31:0] rf_mem [RC];
  logic [RC-1:0] rf_vld_q;
  logic [31:0] rf_a_raw_q, rf_b_raw_q;
  logic [31:0] dmem [tce_pkg::DATA_WORDS];
  logic [31:0] mem_rdata_q;

  logic [31:0] a_val_q, b_val_q;
  logic [AW-1:0] a_idx_q, b_idx_q;

  // execute results
  logic        wr_q, outv_q, derr_q, mwe_q;
  logic [31:0] wval_q, oval_q, mwdata_q;
  logic [AW-1:0] maddr_q;
  logic [1:0]  flag_new_q;
  logic [15:0] pc_add_q;

  // divider
  logic [31:0] quo_q, rem_q, dvs_q;
  logic [4:0]  div_cnt_q;
  logic        div_neg_q;

  // output register
  logic        res_v_q;
  logic [15:0] res_pc_q;
  logic [1:0]  res_flag_q;
  logic        res_outv_q, res_wr_q, res_derr_q;
  logic [31:0] res_oval_q, res_wval_q;
  logic [3:0]  res_widx_q;

  function automatic logic [AW-1:0] mem_idx(input logic [31:0] r, input logic [15:0] base);
    logic signed [32:0] diff;
    logic signed [32:0] adj;
    diff = $signed({r[31], r}) - $signed({17'b0, base});
    adj  = diff + $signed({32'b0, diff[32]});
    adj  = adj >>> 1;
    return adj[AW-1:0];
  endfunction

  wire req_fire = req_i.valid && req_i.ready;
  wire out_free = !res_v_q || res_o.ready;
  wire cfg_we   = psel && penable && pwrite && !paddr[2];

  assign req_i.ready = (state_q == S_IDLE);
  assign pready      = 1'b1;
  assign prdata      = paddr[2] ? 32'b0 : {16'b0, base_q};

  // register file read values in S_RREG
  logic [31:0] a_rd, b_rd;
  always_comb begin
    a_rd = (({28'b0, ra_q} < RC) && rf_vld_q[ra_q[$clog2(RC)-1:0]]) ? rf_a_raw_q : 32'b0;
    b_rd = (({28'b0, rb_q} < RC) && rf_vld_q[rb_q[$clog2(RC)-1:0]]) ? rf_b_raw_q : 32'b0;
  end
  wire [AW-1:0] b_idx_rd = mem_idx(b_rd, base_q);

  // execute
  logic [31:0] operand, ex_wval, ex_oval, ex_mwdata;
  logic        ex_wr, ex_outv, ex_derr, ex_mwe, ex_div;
  logic [AW-1:0] ex_maddr;
  logic [1:0]  ex_flag;
  logic [15:0] ex_pc_add;
  logic [31:0] prod;
  always_comb begin
    operand   = (rb_q == 4'd0) ? {{16{imm_q[15]}}, imm_q} : mem_rdata_q;
    prod      = a_val_q * operand;
    ex_wr     = 1'b0;
    ex_wval   = 32'b0;
    ex_outv   = 1'b0;
    ex_oval   = 32'b0;
    ex_derr   = 1'b0;
    ex_mwe    = 1'b0;
    ex_maddr  = b_idx_q;
    ex_mwdata = 32'b0;
    ex_flag   = flag_q;
    ex_pc_add = tce_pkg::PC_STEP;
    ex_div    = 1'b0;
    case (op_q)
      tce_pkg::OP_MOVE: begin
        if (rb_q == 4'd0) begin
          ex_wr = 1'b1; ex_wval = operand;
        end else if (rb_q >= 4'd5) begin
          ex_wr = 1'b1; ex_wval = mem_rdata_q;
        end else begin
          ex_mwe = 1'b1; ex_maddr = a_idx_q; ex_mwdata = b_val_q;
        end
      end
      tce_pkg::OP_ADD: begin
        ex_wr = 1'b1; ex_wval = a_val_q + operand;
      end
      tce_pkg::OP_SUB: begin
        ex_wr = 1'b1; ex_wval = a_val_q - operand;
      end
      tce_pkg::OP_MUL: begin
        ex_wr = 1'b1; ex_wval = prod;
      end
      tce_pkg::OP_DIV: begin
        if (operand == 32'b0) ex_derr = 1'b1;
        else ex_div = 1'b1;
      end
      tce_pkg::OP_AND: begin
        ex_wr = 1'b1; ex_wval = {31'b0, (a_val_q != 32'b0) && (operand != 32'b0)};
      end
      tce_pkg::OP_OR: begin
        ex_wr = 1'b1; ex_wval = {31'b0, (a_val_q != 32'b0) || (operand != 32'b0)};
      end
      tce_pkg::OP_NOT: begin
        if (rb_q == 4'd0) begin
          ex_wr = 1'b1; ex_wval = {31'b0, a_val_q == 32'b0};
        end else begin
          ex_mwe = 1'b1; ex_mwdata = {31'b0, mem_rdata_q == 32'b0};
        end
      end
      tce_pkg::OP_CMP: begin
        if ($signed(a_val_q) > $signed(operand)) ex_flag = tce_pkg::FLAG_GT;
        else if (a_val_q == operand) ex_flag = tce_pkg::FLAG_EQ;
        else ex_flag = tce_pkg::FLAG_LT;
      end
      tce_pkg::OP_JUMP: begin
        if ((rb_q == tce_pkg::JMP_ALWAYS) ||
            (rb_q == tce_pkg::JMP_EQ && flag_q == tce_pkg::FLAG_EQ) ||
            (rb_q == tce_pkg::JMP_GT && flag_q == tce_pkg::FLAG_GT) ||
            (rb_q == tce_pkg::JMP_LT && flag_q == tce_pkg::FLAG_LT))
          ex_pc_add = imm_q;
      end
      tce_pkg::OP_IN: begin
        ex_wr = 1'b1; ex_wval = inval_q;
      end
      tce_pkg::OP_OUT: begin
        ex_outv = 1'b1; ex_oval = a_val_q;
      end
      default: ;
    endcase
    if ({28'b0, ra_q} >= RC) ex_wr = 1'b0;
  end

  // divider step
  logic [32:0] rem_sh, rem_sub;
  logic [31:0] rem_nx, quo_nx;
  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (!rem_sub[32]) begin
      rem_nx = rem_sub[31:0];
      quo_nx = {quo_q[30:0], 1'b1};
    end else begin
      rem_nx = rem_sh[31:0];
      quo_nx = {quo_q[30:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_cnt_q == AW'(tce_pkg::DATA_WORDS - 1)) state_d = S_IDLE;
      S_IDLE: if (req_fire) state_d = S_RREG;
      S_RREG: state_d = S_EXEC;
      S_EXEC: state_d = ex_div ? S_DIV : S_WB;
      S_DIV:  if (div_cnt_q == 5'd31) state_d = S_WB;
      S_WB:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      base_q    <= tce_pkg::BASE_RESET;
      pc_q      <= 16'b0;
      flag_q    <= tce_pkg::FLAG_EQ;
      clr_cnt_q <= '0;
      rf_vld_q  <= '0;
      res_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) base_q <= pwdata[15:0];
      if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (res_v_q && res_o.ready) res_v_q <= 1'b0;
      if (state_q == S_WB && out_free) begin
        res_v_q <= 1'b1;
        pc_q    <= pc_q + pc_add_q;
        flag_q  <= flag_new_q;
        if (wr_q) rf_vld_q[ra_q[$clog2(RC)-1:0]] <= 1'b1;
      end
    end
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (state_q == S_WB && out_free && wr_q) rf_mem[ra_q[$clog2(RC)-1:0]] <= wval_q;
    if (req_fire) begin
      rf_a_raw_q <= rf_mem[req_i.reg_a[$clog2(RC)-1:0]];
      rf_b_raw_q <= rf_mem[req_i.reg_b[$clog2(RC)-1:0]];
    end
  end

  // data memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) dmem[clr_cnt_q] <= 32'b0;
    else if (state_q == S_WB && out_free && mwe_q) dmem[maddr_q] <= mwdata_q;
    if (state_q == S_RREG) mem_rdata_q <= dmem[b_idx_rd];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.opcode;
      ra_q    <= req_i.reg_a;
      rb_q    <= req_i.reg_b;
      imm_q   <= req_i.immediate;
      inval_q <= req_i.in_value;
    end
    if (state_q == S_RREG) begin
      a_val_q <= a_rd;
      b_val_q <= b_rd;
      a_idx_q <= mem_idx(a_rd, base_q);
      b_idx_q <= b_idx_rd;
    end
    if (state_q == S_EXEC) begin
      wr_q       <= ex_wr || ex_div;
      wval_q     <= ex_wval;
      outv_q     <= ex_outv;
      oval_q     <= ex_oval;
      derr_q     <= ex_derr;
      mwe_q      <= ex_mwe;
      maddr_q    <= ex_maddr;
      mwdata_q   <= ex_mwdata;
      flag_new_q <= ex_flag;
      pc_add_q   <= ex_pc_add;
      quo_q      <= a_val_q[31] ? -a_val_q : a_val_q;
      dvs_q      <= operand[31] ? -operand : operand;
      rem_q      <= 32'b0;
      div_cnt_q  <= 5'd0;
      div_neg_q  <= a_val_q[31] ^ operand[31];
    end
    if (state_q == S_DIV) begin
      quo_q     <= quo_nx;
      rem_q     <= rem_nx;
      div_cnt_q <= div_cnt_q + 5'd1;
      if (div_cnt_q == 5'd31) wval_q <= div_neg_q ? -quo_nx : quo_nx;
      if ({28'b0, ra_q} >= RC) wr_q <= 1'b0;
    end
    if (state_q == S_WB && out_free) begin
      res_pc_q   <= pc_q + pc_add_q;
      res_flag_q <= flag_new_q;
      res_outv_q <= outv_q;
      res_oval_q <= oval_q;
      res_wr_q   <= wr_q;
      res_widx_q <= wr_q ? ra_q : 4'd0;
      res_wval_q <= wr_q ? wval_q : 32'b0;
      res_derr_q <= derr_q;
    end
  end

  assign res_o.valid         = res_v_q;
  assign res_o.next_pc       = res_pc_q;
  assign res_o.flag          = res_flag_q;
  assign res_o.out_valid     = res_outv_q;
  assign res_o.out_value     = res_oval_q;
  assign res_o.reg_written   = res_wr_q;
  assign res_o.written_index = res_widx_q;
  assign res_o.written_value = res_wval_q;
  assign res_o.divide_error  = res_derr_q;

  a_fire_rreg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_RREG) else $error("request not followed by register read");

  a_derr_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.divide_error && res_o.reg_written))
    else $error("divide error with register write");

  a_flag_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q != 2'b10) else $error("illegal compare flag");

  a_clr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !req_i.ready && !res_o.valid)
    else $error("activity during memory clear");

endmodule

// ----- dv/exec_scoreboard.sv -----
class exec_scoreboard;
  typedef struct packed {
    logic [15:0] next_pc;
    logic [1:0]  flag;
    logic        out_valid;
    logic [31:0] out_value;
    logic        reg_written;
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        divide_error;
  } outcome_t;

  logic [15:0] base;
  logic [15:0] pc;
  logic [1:0]  flag;
  logic [31:0] regs [tce_pkg::REG_COUNT];
  logic [31:0] mem [tce_pkg::DATA_WORDS];
  outcome_t    pending [$];
  int          errors;

  function new();
    base = tce_pkg::BASE_RESET;
    pc = '0;
    flag = tce_pkg::FLAG_EQ;
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    errors = 0;
  endfunction

  function logic [31:0] reg_value(logic [3:0] idx);
    return (idx < tce_pkg::REG_COUNT) ? regs[idx] : 32'd0;
  endfunction

  function int unsigned word_index(logic [31:0] r);
    longint diff;
    longint q;
    diff = longint'($signed(r)) - longint'(base);
    q = diff / 2;
    return int'(q[tce_pkg::MEM_AW-1:0]);
  endfunction

  function void note_request(logic [7:0] op, logic [3:0] ra, logic [3:0] rb,
                             logic [15:0] imm, logic [31:0] inval);
    outcome_t o;
    logic [31:0] a, immw, opnd, wval;
    int unsigned bidx;
    logic wr;
    logic [15:0] step;
    longint q;
    a = reg_value(ra);
    immw = {{16{imm[15]}}, imm};
    bidx = word_index(reg_value(rb));
    opnd = (rb == 0) ? immw : mem[bidx];
    o = '0;
    wr = 1'b0;
    wval = '0;
    step = tce_pkg::PC_STEP;
    case (op)
      tce_pkg::OP_MOVE: begin
        if (rb == 0) begin
          wr = 1'b1; wval = immw;
        end else if (rb >= 5) begin
          wr = 1'b1; wval = mem[bidx];
        end else begin
          mem[word_index(a)] = reg_value(rb);
        end
      end
      tce_pkg::OP_ADD: begin wr = 1'b1; wval = a + opnd; end
      tce_pkg::OP_SUB: begin wr = 1'b1; wval = a - opnd; end
      tce_pkg::OP_MUL: begin wr = 1'b1; wval = a * opnd; end
      tce_pkg::OP_DIV: begin
        if (opnd == 0) begin
          o.divide_error = 1'b1;
        end else begin
          q = longint'($signed(a)) / longint'($signed(opnd));
          wr = 1'b1; wval = q[31:0];
        end
      end
      tce_pkg::OP_AND: begin wr = 1'b1; wval = {31'b0, (a != 0 && opnd != 0)}; end
      tce_pkg::OP_OR: begin wr = 1'b1; wval = {31'b0, (a != 0 || opnd != 0)}; end
      tce_pkg::OP_NOT: begin
        if (rb == 0) begin
          wr = 1'b1; wval = {31'b0, (a == 0)};
        end else begin
          mem[bidx] = {31'b0, (mem[bidx] == 0)};
        end
      end
      tce_pkg::OP_CMP: begin
        if ($signed(a) > $signed(opnd)) flag = tce_pkg::FLAG_GT;
        else if (a == opnd) flag = tce_pkg::FLAG_EQ;
        else flag = tce_pkg::FLAG_LT;
      end
      tce_pkg::OP_JUMP: begin
        if (rb == tce_pkg::JMP_ALWAYS || (rb == tce_pkg::JMP_EQ && flag == tce_pkg::FLAG_EQ)
            || (rb == tce_pkg::JMP_GT && flag == tce_pkg::FLAG_GT)
            || (rb == tce_pkg::JMP_LT && flag == tce_pkg::FLAG_LT))
          step = imm;
      end
      tce_pkg::OP_IN: begin wr = 1'b1; wval = inval; end
      tce_pkg::OP_OUT: begin o.out_valid = 1'b1; o.out_value = a; end
      default: ;
    endcase
    if (ra >= tce_pkg::REG_COUNT) wr = 1'b0;
    if (wr) begin
      regs[ra] = wval;
      o.reg_written = 1'b1;
      o.written_index = ra;
      o.written_value = wval;
    end
    pc = pc + step;
    o.next_pc = pc;
    o.flag = flag;
    pending.push_back(o);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endfunction

  function void check_result(outcome_t got);
    outcome_t w;
    if (pending.size() == 0) begin
      $display("mismatch: result with nothing outstanding");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.next_pc !== w.next_pc) report("next_pc", got.next_pc, w.next_pc);
    if (got.flag !== w.flag) report("flag", got.flag, w.flag);
    if (got.out_valid !== w.out_valid) report("out_valid", got.out_valid, w.out_valid);
    if (got.out_value !== w.out_value) report("out_value", got.out_value, w.out_value);
    if (got.reg_written !== w.reg_written)
      report("reg_written", got.reg_written, w.reg_written);
    if (got.written_index !== w.written_index)
      report("written_index", got.written_index, w.written_index);
    if (got.written_value !== w.written_value)
      report("written_value", got.written_value, w.written_value);
    if (got.divide_error !== w.divide_error)
      report("divide_error", got.divide_error, w.divide_error);
  endfunction
endclass

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int send_idle = 24;
  int recv_idle = 57;
  exec_scoreboard sb;

  tce_req_if req();
  tce_res_if res();

  toy_cpu_execute_unit_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .res_o(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.opcode = '0;
    req.reg_a = '0;
    req.reg_b = '0;
    req.immediate = '0;
    req.in_value = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && res.valid && res.ready)
      sb.check_result({res.next_pc, res.flag, res.out_valid, res.out_value, res.reg_written,
                       res.written_index, res.written_value, res.divide_error});
  end

  task automatic send(logic [7:0] op, logic [3:0] ra, logic [3:0] rb,
                      logic [15:0] imm, logic [31:0] inval);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.reg_a <= ra;
    req.reg_b <= rb;
    req.immediate <= imm;
    req.in_value <= inval;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(op, ra, rb, imm, inval);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_base(logic [15:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.base = value;
  endtask

  // base register near the base so memory words are reached in range
  task automatic random_item(logic [15:0] base);
    logic [7:0] op;
    logic [3:0] ra, rb;
    int k;
    k = $urandom_range(99);
    op = (k < 5) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
    ra = 4'($urandom);
    rb = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom);
    if (k >= 5 && k < 20)
      send(tce_pkg::OP_IN, ra, 4'd0, '0,
           {16'd0, base} + 32'($urandom_range(2 * tce_pkg::DATA_WORDS + 40)) - 32'd20);
    else
      send(op, ra, rb, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8)),
           ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom);
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(tce_pkg::OP_MOVE, 4'd1, 4'd0, 16'h7fff, '0);
    send(tce_pkg::OP_MOVE, 4'd2, 4'd0, 16'h8000, '0);
    send(tce_pkg::OP_IN, 4'd3, 4'd0, '0, 32'h8000_0000);
    send(tce_pkg::OP_IN, 4'd4, 4'd0, '0, 32'hffff_ffff);
    send(tce_pkg::OP_IN, 4'd5, 4'd0, '0, 32'd16384);
    send(tce_pkg::OP_IN, 4'd6, 4'd0, '0, 32'd16386);
    send(tce_pkg::OP_MOVE, 4'd5, 4'd1, '0, '0);
    send(tce_pkg::OP_MOVE, 4'd7, 4'd5, '0, '0);
    send(tce_pkg::OP_ADD, 4'd1, 4'd0, 16'hffff, '0);
    send(tce_pkg::OP_SUB, 4'd3, 4'd0, 16'd1, '0);
    send(tce_pkg::OP_MUL, 4'd1, 4'd6, '0, '0);
    send(tce_pkg::OP_DIV, 4'd3, 4'd0, 16'hffff, '0);
    send(tce_pkg::OP_DIV, 4'd1, 4'd0, 16'd0, '0);
    send(tce_pkg::OP_AND, 4'd1, 4'd0, 16'd0, '0);
    send(tce_pkg::OP_OR, 4'd1, 4'd0, 16'd3, '0);
    send(tce_pkg::OP_NOT, 4'd0, 4'd0, '0, '0);
    send(tce_pkg::OP_NOT, 4'd0, 4'd6, '0, '0);
    send(tce_pkg::OP_CMP, 4'd3, 4'd0, 16'd0, '0);
    send(tce_pkg::OP_JUMP, 4'd0, tce_pkg::JMP_LT, 16'hfff0, '0);
    send(tce_pkg::OP_JUMP, 4'd0, tce_pkg::JMP_EQ, 16'h0100, '0);
    send(tce_pkg::OP_JUMP, 4'd0, tce_pkg::JMP_ALWAYS, 16'h8000, '0);
    send(tce_pkg::OP_OUT, 4'd15, 4'd0, '0, '0);
    send(tce_pkg::OP_STOP, 4'd0, 4'd0, '0, '0);
    send(8'hff, 4'd0, 4'd0, '0, '0);
    write_base(16'd0);
    for (phase = 0; phase < 5; phase++) begin
      logic [15:0] b;
      if (phase == 1) begin send_idle = 57; recv_idle = 24; end
      if (phase == 2) write_base(16'hffff);
      if (phase == 3) begin send_idle = 0; recv_idle = 0; write_base(16'h1234); end
      if (phase == 4) write_base(tce_pkg::BASE_RESET);
      b = sb.base;
      repeat (300) random_item(b);
      if (phase == 0) drain();
    end
    drain();
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
